[hw/rtl/rspe_pkg.sv]
package rspe_pkg;

    // Default build: GF(2^8) with up to 32 parity symbols.
    localparam int P_SYMBOL_BITS = 8;
    localparam int P_MAX_PARITY  = 32;

    // Width of the symbol fields on the streaming ports.
    localparam int P_PORT_SYM_W = 8;

    // Depth of the queue between the front and the back end.
    localparam int P_QUEUE_DEPTH = 4;

    // Register reset values.
    localparam int P_FIELD_POLY_RESET = 285;
    localparam int P_CODEWORD_LEN_RESET = 255;
    localparam int P_MESSAGE_LEN_RESET = 223;

    // APB register map, one 32-bit word per register.
    localparam int P_PADDR_W = 4;
    localparam int P_PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_FIELD_POLY   = 2'd0,
        REG_CODEWORD_LEN = 2'd1,
        REG_MESSAGE_LEN  = 2'd2
    } t_rspe_reg;

    typedef struct packed {
        logic [P_PORT_SYM_W-1:0] message_symbol;
    } t_rspe_msg;

    typedef struct packed {
        logic [P_PORT_SYM_W-1:0] code_symbol;
        logic                    is_parity;
        logic                    last;
        logic                    config_error;
    } t_rspe_code;

    // Classified message symbol as it travels from the front to the back end.
    typedef struct packed {
        logic [P_PORT_SYM_W-1:0] symbol;
        logic                    last_msg;
        logic                    cfg_err;
    } t_rspe_item;

endpackage

[hw/rtl/rspe_stream_if.sv]
interface rspe_msg_if import rspe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rspe_msg payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rspe_code_if import rspe_pkg::*; ();
    logic       valid;
    logic       ready;
    t_rspe_code payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/reed_solomon_parity_encoder.sv]
// An accepted message symbol passes the queue and then the output register. Throughput: one
// message symbol per cycle while the output is not stalled and no rebuild runs; after the k-th
// symbol of a codeword the output carries the r = n - k parity symbols, during which input fills
// the queue and then backs up. Reset is synchronous and active low; after reset and after every
// register write the generator polynomial is rebuilt, and no transaction is taken meanwhile.
// The per-lane GF multipliers of the parity LFSR set the single-cycle symbol update.
module reed_solomon_parity_encoder import rspe_pkg::*; #(
    parameter int SYMBOL_BITS = P_SYMBOL_BITS,
    parameter int MAX_PARITY  = P_MAX_PARITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rspe_msg_if.sink               i_msg,
    rspe_code_if.source            o_code,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [P_PADDR_W-1:0]   paddr,
    input  logic [P_PDATA_W-1:0]   pwdata,
    output logic [P_PDATA_W-1:0]   prdata,
    output logic                   pready
);

    localparam int SB = SYMBOL_BITS;
    localparam int RW = $clog2(MAX_PARITY + 1);

    // Configuration registers. The field polynomial includes the x^m term,
    // so it is one bit wider than a symbol.
    logic [SB:0] r_field_poly;
    logic [7:0]  r_codeword_len;
    logic [7:0]  r_message_len;
    // One-cycle request to rebuild the generator and clear the encoder state.
    // It comes up out of reset so the default configuration is built as well.
    logic        r_start;

    logic          w_wr;
    t_rspe_reg     w_reg;
    logic [7:0]    w_diff;
    logic          w_cfg_err;
    logic [RW-1:0] w_parity_count;
    logic          w_back_busy;
    logic          w_busy;
    logic          w_push;
    logic          w_full;
    logic          w_q_valid;
    logic          w_pop;
    t_rspe_item    w_push_item;
    t_rspe_item    w_q_item;

    // APB: zero wait states, register selected by the word address.
    assign pready = 1'b1;
    assign w_reg  = t_rspe_reg'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        case (w_reg)
            REG_FIELD_POLY:   prdata = P_PDATA_W'(r_field_poly);
            REG_CODEWORD_LEN: prdata = P_PDATA_W'(r_codeword_len);
            REG_MESSAGE_LEN:  prdata = P_PDATA_W'(r_message_len);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_poly   <= (SB+1)'(P_FIELD_POLY_RESET);
            r_codeword_len <= 8'(P_CODEWORD_LEN_RESET);
            r_message_len  <= 8'(P_MESSAGE_LEN_RESET);
            r_start        <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (w_wr) begin
                case (w_reg)
                    REG_FIELD_POLY: begin
                        r_field_poly <= pwdata[SB:0];
                        r_start      <= 1'b1;
                    end
                    REG_CODEWORD_LEN: begin
                        r_codeword_len <= pwdata[7:0];
                        r_start        <= 1'b1;
                    end
                    REG_MESSAGE_LEN: begin
                        r_message_len <= pwdata[7:0];
                        r_start       <= 1'b1;
                    end
                    default: begin
                        // Writes past the register map are dropped.
                    end
                endcase
            end
        end
    end

    // A codeword needs at least one message symbol and between one and
    // MAX_PARITY parity symbols. Otherwise every symbol is passed through
    // with the error flag and no parity is produced.
    assign w_diff         = r_codeword_len - r_message_len;
    assign w_cfg_err      = (r_codeword_len <= r_message_len) || (r_message_len == 8'd0)
                            || (w_diff > 8'(MAX_PARITY));
    assign w_parity_count = RW'(w_diff);

    // Input is held off while a rebuild is pending or running.
    assign w_busy = r_start || w_back_busy;

    // Front end: takes message transactions, counts symbols within the
    // codeword and marks the one that ends the message part.
    rspe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (r_start),
        .i_busy        (w_busy),
        .i_cfg_err     (w_cfg_err),
        .i_message_len (r_message_len),
        .i_msg         (i_msg),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    // Short queue so message intake keeps going while the back end is held
    // by a stalled output or by parity emission.
    rspe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (r_start),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Back end: generator build, parity LFSR and the output register.
    rspe_back #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_PARITY  (MAX_PARITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_start),
        .i_cfg_err      (w_cfg_err),
        .i_parity_count (w_parity_count),
        .i_field_poly   (r_field_poly),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_pop),
        .o_busy         (w_back_busy),
        .o_code         (o_code)
    );

endmodule

[hw/rtl/rspe_front.sv]
module rspe_front import rspe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_busy,
    input  logic                    i_cfg_err,
    input  logic [7:0]              i_message_len,
    rspe_msg_if.sink                i_msg,
    input  logic                    i_queue_full,
    output logic                    o_push,
    output t_rspe_item              o_item
);

    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       w_last_msg;

    assign i_msg.ready = !i_queue_full && !i_busy;
    assign o_push      = i_msg.valid && i_msg.ready;

    // The symbol that brings the count up to k closes the message part.
    assign w_last_msg = ({1'b0, r_count} + 9'd1) >= {1'b0, i_message_len};

    assign o_item.symbol   = i_msg.payload.message_symbol;
    assign o_item.last_msg = w_last_msg && !i_cfg_err;
    assign o_item.cfg_err  = i_cfg_err;

    always_comb begin
        n_count = r_count;
        if (o_push && !i_cfg_err) begin
            n_count = w_last_msg ? 8'd0 : r_count + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= 8'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/rspe_queue.sv]
module rspe_queue import rspe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_flush,
    input  logic       i_push,
    input  t_rspe_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_rspe_item o_item
);

    localparam int DEPTH = P_QUEUE_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rspe_item r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/rspe_back.sv]
module rspe_back import rspe_pkg::*; #(
    parameter int SYMBOL_BITS = P_SYMBOL_BITS,
    parameter int MAX_PARITY  = P_MAX_PARITY,
    localparam int RW = $clog2(MAX_PARITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_cfg_err,
    input  logic [RW-1:0]          i_parity_count,
    input  logic [SYMBOL_BITS:0]   i_field_poly,
    input  logic                   i_q_valid,
    input  t_rspe_item             i_q_item,
    output logic                   o_q_pop,
    output logic                   o_busy,
    rspe_code_if.source            o_code
);

    localparam int SB = SYMBOL_BITS;
    localparam int MP = MAX_PARITY;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PARITY,
        ST_DERIVE
    } t_state;

    function automatic logic [SB-1:0] gf_xtime(input logic [SB-1:0] a,
                                               input logic [SB-1:0] taps);
        return {a[SB-2:0], 1'b0} ^ (a[SB-1] ? taps : '0);
    endfunction

    function automatic logic [SB-1:0] gf_mul(input logic [SB-1:0] a,
                                             input logic [SB-1:0] b,
                                             input logic [SB-1:0] taps);
        logic [SB-1:0] acc;
        logic [SB-1:0] sh;
        acc = '0;
        sh  = a;
        for (int i = 0; i < SB; i++) begin
            if (b[i]) begin
                acc = acc ^ sh;
            end
            sh = gf_xtime(sh, taps);
        end
        return acc;
    endfunction

    t_state        r_state;
    logic [RW-1:0] r_cnt;
    logic [SB-1:0] r_alpha;
    // Parity lanes are aligned to the top: the active window is
    // MAX_PARITY-r .. MAX_PARITY-1, lanes below it stay zero.
    logic [SB-1:0] r_par [MP];
    // Generator coefficients share the same alignment; the extra top entry
    // holds the leading coefficient while the generator is built.
    logic [SB-1:0] r_gen [MP+1];
    logic          r_out_valid;
    t_rspe_code    r_out;

    logic [SB-1:0] w_taps;
    logic [SB-1:0] w_alpha_n;
    logic [SB-1:0] w_sym;
    logic [SB-1:0] w_fb;
    logic [SB-1:0] w_mul_b;
    logic [SB-1:0] w_prod [MP+1];
    logic [RW-1:0] w_gen_base;
    logic          w_out_free;
    logic          w_par_zero;

    assign w_taps     = i_field_poly[SB-1:0];
    assign w_alpha_n  = gf_xtime(r_alpha, w_taps);
    assign w_sym      = SB'(i_q_item.symbol);
    assign w_fb       = w_sym ^ r_par[MP-1];
    assign w_mul_b    = (r_state == ST_DERIVE) ? w_alpha_n : w_fb;
    assign w_gen_base = RW'(MP) - i_parity_count;
    assign w_out_free = !r_out_valid || o_code.ready;

    // One multiplier per lane, shared by generator build and parity update.
    always_comb begin
        for (int p = 0; p <= MP; p++) begin
            w_prod[p] = gf_mul(r_gen[p], w_mul_b, w_taps);
        end
    end

    always_comb begin
        w_par_zero = 1'b1;
        for (int p = 0; p < MP; p++) begin
            if (r_par[p] != '0) begin
                w_par_zero = 1'b0;
            end
        end
    end

    assign o_q_pop      = (r_state == ST_RUN) && i_q_valid && w_out_free && !i_start;
    assign o_busy       = (r_state == ST_DERIVE);
    assign o_code.valid = r_out_valid;
    assign o_code.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_out_valid <= 1'b0;
                r_alpha     <= SB'(1);
                r_cnt       <= i_parity_count;
                r_state     <= i_cfg_err ? ST_RUN : ST_DERIVE;
                for (int p = 0; p < MP; p++) begin
                    r_par[p] <= '0;
                end
                for (int p = 0; p <= MP; p++) begin
                    r_gen[p] <= (RW'(p) == w_gen_base) ? SB'(1) : '0;
                end
            end else begin
                case (r_state)
                    ST_RUN: begin
                        if (o_q_pop) begin
                            r_out_valid        <= 1'b1;
                            r_out.code_symbol  <= P_PORT_SYM_W'(w_sym);
                            r_out.is_parity    <= 1'b0;
                            r_out.last         <= 1'b0;
                            r_out.config_error <= i_q_item.cfg_err;
                            if (!i_q_item.cfg_err) begin
                                r_par[0] <= w_prod[0];
                                for (int p = 1; p < MP; p++) begin
                                    r_par[p] <= r_par[p-1] ^ w_prod[p];
                                end
                                if (i_q_item.last_msg) begin
                                    r_cnt   <= i_parity_count;
                                    r_state <= ST_PARITY;
                                end
                            end
                        end else if (o_code.ready) begin
                            r_out_valid <= 1'b0;
                        end
                    end
                    ST_PARITY: begin
                        if (w_out_free) begin
                            r_out_valid        <= 1'b1;
                            r_out.code_symbol  <= P_PORT_SYM_W'(r_par[MP-1]);
                            r_out.is_parity    <= 1'b1;
                            r_out.last         <= (r_cnt == RW'(1));
                            r_out.config_error <= 1'b0;
                            r_par[0] <= '0;
                            for (int p = 1; p < MP; p++) begin
                                r_par[p] <= r_par[p-1];
                            end
                            r_cnt <= r_cnt - 1'b1;
                            if (r_cnt == RW'(1)) begin
                                r_state <= ST_RUN;
                            end
                        end
                    end
                    ST_DERIVE: begin
                        if (o_code.ready) begin
                            r_out_valid <= 1'b0;
                        end
                        r_alpha  <= w_alpha_n;
                        r_gen[0] <= w_prod[0];
                        for (int p = 1; p <= MP; p++) begin
                            r_gen[p] <= r_gen[p-1] ^ w_prod[p];
                        end
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == RW'(1)) begin
                            r_state <= ST_RUN;
                        end
                    end
                    default: begin
                        if (o_code.ready) begin
                            r_out_valid <= 1'b0;
                        end
                        r_state <= ST_RUN;
                    end
                endcase
            end
        end
    end

    // The last parity symbol leaves the whole LFSR cleared for the next codeword.
    a_par_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PARITY && w_out_free && r_cnt == RW'(1) && !i_start)
        |=> w_par_zero)
        else $error("parity lanes not cleared after the last parity symbol");

    // A finished generator is monic: its leading coefficient lands in the top entry.
    a_gen_monic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DERIVE && r_cnt == RW'(1) && !i_start)
        |=> (r_gen[MP] == SB'(1)))
        else $error("generator polynomial is not monic");

    // Only a parity symbol can close a codeword, and never under a bad configuration.
    a_last_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.is_parity && !r_out.config_error))
        else $error("codeword end flagged on a non-parity result");

    // Nothing leaves the queue while the generator is being built.
    a_no_pop_in_derive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DERIVE || i_start) |=> !$rose(r_out_valid) || r_out.is_parity
        || r_state == ST_RUN)
        else $error("result produced during generator build");

endmodule
